>>> rtl/ppsc_pkg.sv
// Package for the pursuit steering core: datapath widths, CORDIC angle table,
// fixed-point constants and the saturation helper. No dependencies.

package ppsc_pkg;

    // CORDIC datapath: Q8.16 working values with headroom for gain growth
    localparam int CW = 27;
    // Angle accumulator, Q.16 radians
    localparam int ZW = 20;
    // Range in Q9.8, unsigned
    localparam int RW = 17;
    // Heading error in Q3.12, signed
    localparam int EW = 16;

    localparam int ATAN_LEN = 24;

    localparam logic [16:0] ATAN_Q16 [ATAN_LEN] = '{
        17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
        17'd256,   17'd128,   17'd64,    17'd32,   17'd16,   17'd8,    17'd4,    17'd2,
        17'd1,     17'd0,     17'd0,     17'd0,    17'd0,    17'd0,    17'd0,    17'd0
    };

    localparam logic signed [ZW-1:0] HALF_PI_Q16   = ZW'(102944);
    localparam logic [15:0]          INV_GAIN_Q16  = 16'd39797;
    localparam logic [16:0]          SMALL_TURN_Q12 = 17'd410;

    typedef enum logic [1:0] {
        REG_DISTANCE_GAIN     = 2'd0,
        REG_HEADING_GAIN      = 2'd1,
        REG_HEADING_TOLERANCE = 2'd2,
        REG_DESIRED_GAP       = 2'd3
    } cfg_reg_t;

    typedef logic signed [15:0] q8_8_t;

    function automatic q8_8_t sat16(input logic signed [31:0] v);
        q8_8_t r;
        if (v > 32'sd32767)
        begin
            r = 16'sh7fff;
        end
        else if (v < -32'sd32768)
        begin
            r = 16'sh8000;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/ppsc_cordic.sv
// Pipelined vectoring CORDIC: one register stage per iteration, plus the
// quadrant pre-rotation and the gain-corrected range stage. Uses ppsc_pkg.

module ppsc_cordic #(
    parameter int ITER = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [15:0]          in_x,
    input  logic signed [15:0]          in_y,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [ppsc_pkg::RW-1:0]     out_range,
    output logic signed [ppsc_pkg::EW-1:0] out_bearing
);
    import ppsc_pkg::*;

    localparam int LAST = ITER + 1;

    logic [LAST:0]          v_reg;
    logic [LAST:0]          en;
    logic signed [CW-1:0]   x_reg [ITER+1];
    logic signed [CW-1:0]   y_reg [ITER+1];
    logic signed [ZW-1:0]   z_reg [ITER+1];
    logic [ITER:0]          zero_reg;
    logic [RW-1:0]          range_reg;
    logic signed [EW-1:0]   bearing_reg;

    // bubbles collapse: a stage loads when empty or when the next one moves
    assign en[LAST] = !v_reg[LAST] || !out_stall;
    genvar g;
    generate
        for (g = 0; g < LAST; g++)
        begin : g_en
            assign en[g] = !v_reg[g] || en[g+1];
        end
    endgenerate

    assign in_stall = !en[0];

    // stage 0: widen to Q8.16 and fold the left half-plane by +-pi/2
    logic signed [CW-1:0] xw, yw, x0_next, y0_next;
    logic signed [ZW-1:0] z0_next;

    always_comb
    begin
        xw = {{(CW-24){in_x[15]}}, in_x, 8'd0};
        yw = {{(CW-24){in_y[15]}}, in_y, 8'd0};
        x0_next = xw;
        y0_next = yw;
        z0_next = '0;
        if (in_x[15])
        begin
            if (!in_y[15])
            begin
                x0_next = yw;
                y0_next = -xw;
                z0_next = HALF_PI_Q16;
            end
            else
            begin
                x0_next = -yw;
                y0_next = xw;
                z0_next = -HALF_PI_Q16;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en[0])
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            zero_reg[0] <= (in_x == 16'sd0) && (in_y == 16'sd0);
        end
    end

    generate
        for (g = 1; g <= ITER; g++)
        begin : g_iter
            localparam int SH = g - 1;
            localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_Q16[SH]);
            logic signed [CW-1:0] dx, dy, x_next, y_next;
            logic signed [ZW-1:0] z_next;

            always_comb
            begin
                dx = y_reg[g-1] >>> SH;
                dy = x_reg[g-1] >>> SH;
                if (!y_reg[g-1][CW-1])
                begin
                    x_next = x_reg[g-1] + dx;
                    y_next = y_reg[g-1] - dy;
                    z_next = z_reg[g-1] + ANG;
                end
                else
                begin
                    x_next = x_reg[g-1] - dx;
                    y_next = y_reg[g-1] + dy;
                    z_next = z_reg[g-1] - ANG;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v_reg[g] <= 1'b0;
                end
                else if (en[g])
                begin
                    v_reg[g] <= v_reg[g-1];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en[g])
                begin
                    x_reg[g]    <= x_next;
                    y_reg[g]    <= y_next;
                    z_reg[g]    <= z_next;
                    zero_reg[g] <= zero_reg[g-1];
                end
            end
        end
    endgenerate

    // range = x * K, rounded to Q9.8; bearing rounded from Q.16 to Q3.12
    logic [CW-2:0]          x_pos;
    logic [CW+14:0]         range_prod;
    logic signed [ZW-1:0]   z_round;
    logic [RW-1:0]          range_next;
    logic signed [EW-1:0]   bearing_next;

    always_comb
    begin
        x_pos        = x_reg[ITER][CW-1] ? '0 : x_reg[ITER][CW-2:0];
        range_prod   = x_pos * INV_GAIN_Q16 + (CW+15)'(24'h800000);
        z_round      = (z_reg[ITER] + ZW'(8)) >>> 4;
        range_next   = range_prod[24 +: RW];
        bearing_next = z_round[EW-1:0];
        if (zero_reg[ITER])
        begin
            range_next   = '0;
            bearing_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[LAST] <= 1'b0;
        end
        else if (en[LAST])
        begin
            v_reg[LAST] <= v_reg[ITER];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[LAST])
        begin
            range_reg   <= range_next;
            bearing_reg <= bearing_next;
        end
    end

    assign out_valid   = v_reg[LAST];
    assign out_range   = range_reg;
    assign out_bearing = bearing_reg;

    // a full last stage that is not taken still holds next cycle
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[LAST] && out_stall |=> v_reg[LAST])
        else $error("cordic last stage dropped a stalled beat");
    // a filled first stage with a free second stage moves on
    a_move: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[0] && !v_reg[1] |=> v_reg[1])
        else $error("cordic stage one failed to load");
    // stall upstream only when the whole pipe is full
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (&v_reg) && out_stall)
        else $error("cordic stalled with a bubble in the pipe");

endmodule

>>> rtl/pursuit_proportional_steering_core.sv
// Top level of the pursuit steering core: CORDIC pipeline, gain stage and
// output register. Uses ppsc_pkg and ppsc_cordic.
//
// Usage:
//   Input channel (in_valid / in_stall) carries target_found and the target
//   offset in signed Q8.8. A beat with target_found clear is taken and
//   produces no result. Output channel (out_valid / out_stall) carries the
//   saturated linear and angular speed commands in signed Q8.8.
//   Throughput: one beat per cycle unless the receiver stalls, set by the
//   one-iteration-per-stage CORDIC pipeline followed by a gain-multiply
//   stage and the output stage.
//   When the receiver stalls, the pipe keeps filling its empty stages; only
//   once every stage holds a beat does in_stall rise. Nothing is lost.
//   Gains, tolerance and gap come from cfg_write / cfg_index / cfg_data and
//   are to be changed only while the pipe is empty.
//   Reset clears all valid bits and loads the default register values;
//   the block can take a beat in the first cycle after reset.

module pursuit_proportional_steering_core #(
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  ppsc_pkg::cfg_reg_t  cfg_index,
    input  logic [14:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                target_found,
    input  logic signed [15:0]  offset_x,
    input  logic signed [15:0]  offset_y,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [15:0]  linear_speed,
    output logic signed [15:0]  angular_speed
);
    import ppsc_pkg::*;

    logic [11:0] distance_gain_reg;
    logic [11:0] heading_gain_reg;
    logic [13:0] heading_tolerance_reg;
    logic [14:0] desired_gap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            distance_gain_reg     <= 12'd512;
            heading_gain_reg      <= 12'd512;
            heading_tolerance_reg <= 14'd819;
            desired_gap_reg       <= 15'd154;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DISTANCE_GAIN:     distance_gain_reg     <= cfg_data[11:0];
                REG_HEADING_GAIN:      heading_gain_reg      <= cfg_data[11:0];
                REG_HEADING_TOLERANCE: heading_tolerance_reg <= cfg_data[13:0];
                REG_DESIRED_GAP:       desired_gap_reg       <= cfg_data;
                default: ;
            endcase
        end
    end

    logic                   c_valid;
    logic                   c_stall;
    logic [RW-1:0]          c_range;
    logic signed [EW-1:0]   c_bearing;

    ppsc_cordic #(
        .ITER (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid && target_found),
        .in_stall    (in_stall),
        .in_x        (offset_x),
        .in_y        (offset_y),
        .out_valid   (c_valid),
        .out_stall   (c_stall),
        .out_range   (c_range),
        .out_bearing (c_bearing)
    );

    logic mul_valid_reg, out_valid_reg;
    logic en_mul, en_out;

    assign en_out  = !out_valid_reg || !out_stall;
    assign en_mul  = !mul_valid_reg || en_out;
    assign c_stall = !en_mul;

    // gain stage: error magnitudes, gates and the two products
    logic [16:0]            abs_err;
    logic signed [17:0]     gap_diff;
    logic signed [30:0]     lin_prod_next;
    logic signed [28:0]     ang_prod_next;
    logic signed [30:0]     lin_prod_reg;
    logic signed [28:0]     ang_prod_reg;
    logic                   lin_ok_reg, ang_ok_reg;

    always_comb
    begin
        abs_err       = c_bearing[EW-1] ? 17'(-{c_bearing[EW-1], c_bearing})
                                        : 17'({c_bearing[EW-1], c_bearing});
        gap_diff      = $signed({1'b0, c_range}) - $signed({3'b000, desired_gap_reg});
        lin_prod_next = $signed({1'b0, distance_gain_reg}) * gap_diff;
        ang_prod_next = $signed({1'b0, heading_gain_reg}) * c_bearing;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
        end
        else if (en_mul)
        begin
            mul_valid_reg <= c_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            lin_prod_reg <= lin_prod_next;
            ang_prod_reg <= ang_prod_next;
            lin_ok_reg   <= abs_err < {3'b000, heading_tolerance_reg};
            ang_ok_reg   <= abs_err > SMALL_TURN_Q12;
        end
    end

    // rounding, saturation and gating into the output register
    logic signed [31:0] lin_round, ang_round;
    q8_8_t              lin_next, ang_next;
    q8_8_t              lin_reg, ang_reg;

    always_comb
    begin
        lin_round = (32'(lin_prod_reg) + 32'sd128) >>> 8;
        ang_round = (32'(ang_prod_reg) + 32'sd2048) >>> 12;
        lin_next  = lin_ok_reg ? sat16(lin_round) : 16'sd0;
        ang_next  = ang_ok_reg ? sat16(ang_round) : 16'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en_out)
        begin
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            lin_reg <= lin_next;
            ang_reg <= ang_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign linear_speed  = lin_reg;
    assign angular_speed = ang_reg;

    // upstream stalls only behind a stalled result
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output side is free");
    // a gain-stage beat fills an empty output register
    a_fill_out: assert property (@(posedge clk) disable iff (!rst_n)
        mul_valid_reg && !out_valid_reg |=> out_valid_reg)
        else $error("output register failed to load");
    // a lost-target beat enters no stage
    a_drop_lost: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !target_found && !c_valid && !mul_valid_reg
        && !out_valid_reg |=> !out_valid_reg)
        else $error("lost-target beat produced a result");

endmodule

>>> test/pursuit_proportional_steering_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for pursuit_proportional_steering_core: random target beats with random
// input gaps, random output stalls and a scoreboard that predicts every steering command.
// Depends on ppsc_pkg and the core RTL only.

module pursuit_proportional_steering_core_tb;

    import ppsc_pkg::*;

    localparam int     CORDIC_STEPS      = 16;
    localparam int     PIPE_LATENCY      = CORDIC_STEPS + 4;
    localparam longint QUARTER_TURN_Q16  = 102944;
    localparam longint RANGE_SCALE_Q16   = 39797;
    localparam longint TURN_DEADBAND_Q12 = 410;

    typedef struct {
        logic signed [15:0] linear;
        logic signed [15:0] angular;
    } steer_cmd_t;

    class steering_checker;
        longint     dist_gain;
        longint     head_gain;
        longint     head_tol;
        longint     gap;
        longint     atan_q16 [24];
        steer_cmd_t pending_cmds [$];
        int         errors;
        int         checked;
        int         targets;

        function new();
            atan_q16 = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                         256, 128, 64, 32, 16, 8, 4, 2,
                         1, 0, 0, 0, 0, 0, 0, 0};
            dist_gain = 512;
            head_gain = 512;
            head_tol  = 819;
            gap       = 154;
            errors    = 0;
            checked   = 0;
            targets   = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [14:0] data);
            case (idx)
                REG_DISTANCE_GAIN:     dist_gain = data[11:0];
                REG_HEADING_GAIN:      head_gain = data[11:0];
                REG_HEADING_TOLERANCE: head_tol  = data[13:0];
                REG_DESIRED_GAP:       gap       = data[14:0];
                default: ;
            endcase
        endfunction

        function longint clip_q8_8(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        function void note_target(logic found, logic signed [15:0] ox, logic signed [15:0] oy);
            longint     x;
            longint     y;
            longint     z;
            longint     t;
            longint     dx;
            longint     dy;
            longint     range;
            longint     err;
            longint     mag;
            longint     lin;
            longint     ang;
            steer_cmd_t cmd;
            if (!found)
                return;
            targets++;
            x = longint'(ox) * 256;
            y = longint'(oy) * 256;
            z = 0;
            if (ox == 0 && oy == 0)
            begin
                range = 0;
                err   = 0;
            end
            else
            begin
                // pre-rotate into the right half plane
                if (x < 0)
                begin
                    if (y >= 0)
                    begin
                        t = x; x = y; y = -t; z = QUARTER_TURN_Q16;
                    end
                    else
                    begin
                        t = x; x = -y; y = t; z = -QUARTER_TURN_Q16;
                    end
                end
                for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
                begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (y >= 0)
                    begin
                        x += dx; y -= dy; z += atan_q16[i];
                    end
                    else
                    begin
                        x -= dx; y += dy; z -= atan_q16[i];
                    end
                end
                if (x < 0)
                    x = 0;
                range = (x * RANGE_SCALE_Q16 + (longint'(1) << 23)) >>> 24;
                err   = (z + 8) >>> 4;
            end
            mag = (err < 0) ? -err : err;
            lin = 0;
            ang = 0;
            if (mag < head_tol)
                lin = clip_q8_8((dist_gain * (range - gap) + 128) >>> 8);
            if (mag > TURN_DEADBAND_Q12)
                ang = clip_q8_8((head_gain * err + 2048) >>> 12);
            cmd.linear  = 16'(lin);
            cmd.angular = 16'(ang);
            pending_cmds.push_back(cmd);
        endfunction

        function void check_command(logic signed [15:0] lin, logic signed [15:0] ang);
            steer_cmd_t want;
            if (pending_cmds.size() == 0)
            begin
                errors++;
                $display("%0t: command with nothing pending: linear %0d angular %0d",
                         $time, lin, ang);
                return;
            end
            want = pending_cmds.pop_front();
            checked++;
            if (lin !== want.linear)
            begin
                errors++;
                $display("%0t: linear_speed mismatch: expected %0d, actual %0d",
                         $time, want.linear, lin);
            end
            if (ang !== want.angular)
            begin
                errors++;
                $display("%0t: angular_speed mismatch: expected %0d, actual %0d",
                         $time, want.angular, ang);
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write;
    cfg_reg_t           cfg_index;
    logic [14:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               target_found;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    logic               out_valid;
    logic               out_stall;
    logic signed [15:0] linear_speed;
    logic signed [15:0] angular_speed;

    steering_checker sb = new();
    int beats_sent  = 0;
    int lost_beats  = 0;
    int setting_cnt = 1;

    // found, x, y: zero offset, corners, axes, straight behind, deadband edges, lost target
    int dir_found [21] = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1,
                           1, 1, 1, 1, 1, 1, 0, 0, 1, 1};
    int dir_x     [21] = '{0, 32767, -32768, -32768, -1, 32767, 0, 0, 32767, -32768, 256,
                           154, 100, 1000, 1000, 1, -1, 1234, -32768, 0, 5000};
    int dir_y     [21] = '{0, 32767, -32768, 0, 0, 0, 32767, -32768, -32768, 32767, 0,
                           0, 5, 80, 110, 1, -1, -999, 32767, 1, -600};

    pursuit_proportional_steering_core #(
        .CORDIC_ITERATIONS(CORDIC_STEPS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .target_found (target_found),
        .offset_x     (offset_x),
        .offset_y     (offset_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .linear_speed (linear_speed),
        .angular_speed(angular_speed)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_command(linear_speed, angular_speed);
    end

    // receiver: random stalls, one long hold-off, one stretch with no stalls
    initial
    begin
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (!held && sb.checked >= 200)
            begin
                held      = 1;
                hold_left = 150;
                out_stall <= 1'b1;
            end
            else if (sb.checked >= 380 && sb.checked < 500)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 29);
        end
    end

    // entered and left just after a falling edge
    task automatic send_target(logic found, logic signed [15:0] ox, logic signed [15:0] oy);
        while (!(beats_sent >= 400 && beats_sent < 520) && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        target_found <= found;
        offset_x     <= ox;
        offset_y     <= oy;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_target(found, ox, oy);
        beats_sent++;
        if (!found)
            lost_beats++;
        @(negedge clk);
    endtask

    task automatic run_directed();
        for (int i = 0; i < 21; i++)
            send_target(dir_found[i] != 0, 16'(dir_x[i]), 16'(dir_y[i]));
    endtask

    task automatic run_random(int count);
        int x;
        int y;
        bit found;
        for (int i = 0; i < count; i++)
        begin
            found = ($urandom_range(99) < 85);
            case ($urandom_range(3))
                0:
                begin
                    x = $urandom_range(65535) - 32768;
                    y = $urandom_range(65535) - 32768;
                end
                1:
                begin
                    x = $urandom_range(4095) - 2048;
                    y = $urandom_range(4095) - 2048;
                end
                2:
                begin
                    // near the forward axis, where the tolerance and deadband matter
                    x = $urandom_range(8000, 64);
                    y = int'($urandom_range(x / 3)) - x / 6;
                end
                default:
                begin
                    x = ($urandom_range(1)) ? -32768 : $urandom_range(65535) - 32768;
                    y = ($urandom_range(1)) ? 0 : -32768;
                    if ($urandom_range(1))
                    begin
                        y = x;
                        x = 0;
                    end
                end
            endcase
            send_target(found, 16'(x), 16'(y));
        end
    endtask

    // lost targets make no command and enter no stage of the pipe
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending_cmds.size() > 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 8) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [14:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic load_settings(logic [14:0] d_gain, logic [14:0] h_gain,
                                 logic [14:0] h_tol, logic [14:0] d_gap);
        write_reg(REG_DISTANCE_GAIN, d_gain);
        write_reg(REG_HEADING_GAIN, h_gain);
        write_reg(REG_HEADING_TOLERANCE, h_tol);
        write_reg(REG_DESIRED_GAP, d_gap);
        cfg_write <= 1'b0;
        @(negedge clk);
        setting_cnt++;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_DISTANCE_GAIN;
        cfg_data     = '0;
        in_valid     = 1'b0;
        target_found = 1'b0;
        offset_x     = '0;
        offset_y     = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults
        run_directed();
        run_random(120);
        settle();

        // all ones: upper data bits must be dropped
        load_settings(15'h7fff, 15'h7fff, 15'h7fff, 15'h7fff);
        run_directed();
        run_random(120);
        settle();

        load_settings(15'd0, 15'd0, 15'd0, 15'd0);
        run_random(130);
        settle();

        load_settings(15'd256, 15'd4095, 15'd12868, 15'd0);
        run_random(130);
        settle();

        for (int p = 0; p < 3; p++)
        begin
            load_settings(15'($urandom), 15'($urandom), 15'($urandom), 15'($urandom));
            run_random(130);
            settle();
        end

        $display("Covered %0d target beats (%0d lost) under %0d register settings,",
                 beats_sent, lost_beats, setting_cnt);
        $display("with %0d steering commands compared against the prediction.", sb.checked);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Timed out with %0d commands still pending.", sb.pending_cmds.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> files.f
rtl/ppsc_pkg.sv
rtl/ppsc_cordic.sv
rtl/pursuit_proportional_steering_core.sv
test/pursuit_proportional_steering_core_tb.sv
